/* src/gap_pkg.sv */
// shared types, constants and helper functions for the grid path search core
// no dependencies; imported by every module of the block but the generic ram
package gap_pkg;

   localparam int GRID_SIDE     = 8;
   localparam int GRID_BITS     = $clog2(GRID_SIDE);
   localparam int CELL_COUNT    = GRID_SIDE * GRID_SIDE;
   localparam int CELL_BITS     = 2 * GRID_BITS;
   localparam int OPEN_DEPTH    = 256;
   localparam int OPEN_BITS     = $clog2(OPEN_DEPTH);
   localparam int OPEN_CNT_BITS = OPEN_BITS + 1;
   localparam int NUM_DIRS      = 4;

   localparam int COORD_W = 11;
   localparam int TILE_W  = 8;
   localparam int POINT_W = 12;
   localparam int G_W     = CELL_BITS + 1;
   localparam int COST_W  = G_W + 1;
   localparam int F_W     = G_W + 1;
   localparam int SEQ_W   = CELL_BITS + 3;
   localparam int DIV_STEPS = COORD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [TILE_W-1:0] TILE_SIZE_RESET = 8'd32;

   localparam logic [1:0] OP_SET_WALL    = 2'd0;
   localparam logic [1:0] OP_TOGGLE_WALL = 2'd1;
   localparam logic [1:0] OP_QUERY       = 2'd2;
   localparam logic [1:0] OP_FIND_PATH   = 2'd3;

   localparam logic [1:0] KIND_CELL     = 2'd0;
   localparam logic [1:0] KIND_WAYPOINT = 2'd1;
   localparam logic [1:0] KIND_EMPTY    = 2'd2;
   localparam logic [1:0] KIND_OUTSIDE  = 2'd3;

   localparam logic [1:0] DIR_Y_UP   = 2'd0;
   localparam logic [1:0] DIR_Y_DOWN = 2'd1;
   localparam logic [1:0] DIR_X_DOWN = 2'd2;
   localparam logic [1:0] DIR_X_UP   = 2'd3;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_CHECK,
      ST_CELL_RD,
      ST_CELL_WR,
      ST_INIT_RD,
      ST_INIT_WR,
      ST_PUSH_SRC,
      ST_SCAN_START,
      ST_SCAN,
      ST_RM_RD,
      ST_RM_WR,
      ST_POP_CHK,
      ST_NB,
      ST_NB_CHK,
      ST_FIN_RD,
      ST_FIN_CHK,
      ST_BT,
      ST_BT_CHK,
      ST_OUT_RD,
      ST_OUT_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [G_W-1:0]       g;
      logic [CELL_BITS-1:0] node;
      logic [SEQ_W-1:0]     seq;
   } open_entry_type;

   typedef struct packed {
      logic                 closed;
      logic                 known;
      logic [COST_W-1:0]    cost;
      logic [CELL_BITS-1:0] from;
   } cell_info_type;

   typedef struct packed {
      logic                 ok;
      logic [CELL_BITS-1:0] node;
   } neighbor_type;

   typedef struct packed {
      logic               start;
      logic [COORD_W-1:0] dividend;
      logic [TILE_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [COORD_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [GRID_BITS-1:0] gap_dist(logic [GRID_BITS-1:0] a,
                                                     logic [GRID_BITS-1:0] b);
      gap_dist = (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic neighbor_type gap_neighbor(logic [CELL_BITS-1:0] node,
                                                 logic [1:0] dir);
      logic [GRID_BITS-1:0] x;
      logic [GRID_BITS-1:0] y;
      neighbor_type r;
      x = node[CELL_BITS-1:GRID_BITS];
      y = node[GRID_BITS-1:0];
      r.ok = 1'b1;
      unique case (dir)
         DIR_Y_UP: begin
            if (y == GRID_BITS'(GRID_SIDE - 1)) r.ok = 1'b0;
            y = y + 1'b1;
         end
         DIR_Y_DOWN: begin
            if (y == '0) r.ok = 1'b0;
            y = y - 1'b1;
         end
         DIR_X_DOWN: begin
            if (x == '0) r.ok = 1'b0;
            x = x - 1'b1;
         end
         default: begin
            if (x == GRID_BITS'(GRID_SIDE - 1)) r.ok = 1'b0;
            x = x + 1'b1;
         end
      endcase
      r.node = {x, y};
      return r;
   endfunction

endpackage

/* src/grid_astar_path_search_core.sv */
// top level of the grid path search core: command sequencer, wall map and A* search
// depends on gap_pkg, gap_ram and gap_div
//
// The core holds an 8x8 wall map and takes one command at a time: set, toggle or
// query a wall, or find a 4-connected shortest path. After reset a clearing pass
// empties the wall map, and req_ready stays low meanwhile. Every command first
// runs its four coordinates through a shared bit-serial divider: the goal is always
// divided by the tile size, the position only when req_from_world is set.
// A path search then copies the wall map and runs a sequencer over one
// open-list memory port: each pop scans all open entries at one per cycle.
// Waypoints follow one at a time, each held until rsp_ready. req_ready is high
// only while no command is in work; csr writes are always taken and must only
// come while the core is idle.
module grid_astar_path_search_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic                          req_from_world,
   input  logic [gap_pkg::COORD_W-1:0]   req_pos_x,
   input  logic [gap_pkg::COORD_W-1:0]   req_pos_y,
   input  logic [gap_pkg::COORD_W-1:0]   req_goal_x,
   input  logic [gap_pkg::COORD_W-1:0]   req_goal_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_kind,
   output logic                          rsp_occupied,
   output logic [gap_pkg::POINT_W-1:0]   rsp_point_x2,
   output logic [gap_pkg::POINT_W-1:0]   rsp_point_y2,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gap_pkg::TILE_W-1:0]    csr_tile_size
);
   import gap_pkg::*;

   state_type state_ff, state_in;

   logic [CELL_BITS-1:0]     idx_ff, idx_in;
   logic [TILE_W-1:0]        tile_size_ff, tile_size_in;
   logic [1:0]               op_ff, op_in;
   logic                     world_ff, world_in;
   logic [COORD_W-1:0]       pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [COORD_W-1:0]       goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [1:0]               sel_ff, sel_in;
   logic [GRID_BITS-1:0]     px_ff, px_in, py_ff, py_in, tx_ff, tx_in, ty_ff, ty_in;
   logic                     pos_out_ff, pos_out_in, goal_out_ff, goal_out_in;
   logic [OPEN_CNT_BITS-1:0] cnt_ff, cnt_in, rd_idx_ff, rd_idx_in;
   logic [SEQ_W-1:0]         seq_ff, seq_in;
   logic                     pend_ff, pend_in, have_best_ff, have_best_in;
   logic [OPEN_BITS-1:0]     cmp_idx_ff, cmp_idx_in, best_idx_ff, best_idx_in;
   open_entry_type           best_ff, best_in;
   logic [F_W-1:0]           best_f_ff, best_f_in;
   logic [1:0]               dir_ff, dir_in;
   logic [CELL_BITS-1:0]     nb_ff, nb_in, cur_ff, cur_in, steps_ff, steps_in;
   logic                     reached_ff, reached_in;
   logic [CELL_BITS:0]       n_ff, n_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_kind_ff, rsp_kind_in;
   logic                     rsp_occ_ff, rsp_occ_in;
   logic [POINT_W-1:0]       rsp_px_ff, rsp_px_in, rsp_py_ff, rsp_py_in;
   logic                     rsp_last_ff, rsp_last_in;

   // memories
   logic                     wall_we, wall_wd, wall_rd;
   logic [CELL_BITS-1:0]     wall_wa, wall_ra;
   logic                     info_we;
   logic [CELL_BITS-1:0]     info_wa, info_ra;
   cell_info_type            info_wd, info_rd;
   logic                     open_we;
   logic [OPEN_BITS-1:0]     open_wa, open_ra;
   open_entry_type           open_wd, open_rd;
   logic                     stack_we;
   logic [CELL_BITS-1:0]     stack_wa, stack_ra, stack_wd, stack_rd;

   div_req_type              div_req;
   div_rsp_type              div_rsp;

   // datapath helpers
   logic [TILE_W-1:0]        eff_size;
   logic [CELL_BITS-1:0]     src_cell, tgt_cell;
   logic                     issue, last_dir, open_full, outside, cell_bit, search_fail;
   logic [F_W-1:0]           scan_f;
   logic                     scan_better;
   neighbor_type             nb;
   logic [COST_W-1:0]        nb_cost;
   logic [GRID_BITS:0]       wp_x, wp_y;

   gap_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_wall_ram (
      .clock(clock), .wr_en(wall_we), .wr_addr(wall_wa), .wr_data(wall_wd),
      .rd_addr(wall_ra), .rd_data(wall_rd)
   );

   gap_ram #(.WIDTH($bits(cell_info_type)), .DEPTH(CELL_COUNT)) u_info_ram (
      .clock(clock), .wr_en(info_we), .wr_addr(info_wa), .wr_data(info_wd),
      .rd_addr(info_ra), .rd_data(info_rd)
   );

   gap_ram #(.WIDTH($bits(open_entry_type)), .DEPTH(OPEN_DEPTH)) u_open_ram (
      .clock(clock), .wr_en(open_we), .wr_addr(open_wa), .wr_data(open_wd),
      .rd_addr(open_ra), .rd_data(open_rd)
   );

   gap_ram #(.WIDTH(CELL_BITS), .DEPTH(CELL_COUNT)) u_stack_ram (
      .clock(clock), .wr_en(stack_we), .wr_addr(stack_wa), .wr_data(stack_wd),
      .rd_addr(stack_ra), .rd_data(stack_rd)
   );

   gap_div u_div (
      .clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp)
   );

   assign eff_size  = (tile_size_ff == '0) ? TILE_W'(1) : tile_size_ff;
   assign src_cell  = {px_ff, py_ff};
   assign tgt_cell  = {tx_ff, ty_ff};
   assign issue     = rd_idx_ff < cnt_ff;
   assign last_dir  = dir_ff == 2'(NUM_DIRS - 1);
   assign open_full = cnt_ff == OPEN_CNT_BITS'(OPEN_DEPTH);
   assign outside   = pos_out_ff || (op_ff == OP_FIND_PATH && goal_out_ff);
   assign search_fail = !(reached_ff || info_rd.known) || (src_cell == tgt_cell);

   assign scan_f = F_W'(open_rd.g)
                 + F_W'(gap_dist(open_rd.node[CELL_BITS-1:GRID_BITS], tx_ff))
                 + F_W'(gap_dist(open_rd.node[GRID_BITS-1:0], ty_ff));
   assign scan_better = !have_best_ff || (scan_f < best_f_ff)
                     || (scan_f == best_f_ff && (open_rd.g > best_ff.g
                     || (open_rd.g == best_ff.g && open_rd.seq < best_ff.seq)));

   assign nb      = gap_neighbor(best_ff.node, dir_ff);
   assign nb_cost = COST_W'(best_ff.g) + COST_W'(1)
                  + COST_W'(gap_dist(nb_ff[CELL_BITS-1:GRID_BITS], tx_ff))
                  + COST_W'(gap_dist(nb_ff[GRID_BITS-1:0], ty_ff));

   assign wp_x = {stack_rd[CELL_BITS-1:GRID_BITS], 1'b1};
   assign wp_y = {stack_rd[GRID_BITS-1:0], 1'b1};

   always_comb begin
      unique case (op_ff)
         OP_SET_WALL:    cell_bit = 1'b1;
         OP_TOGGLE_WALL: cell_bit = ~wall_rd;
         default:        cell_bit = wall_rd;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:      if (idx_ff == CELL_BITS'(CELL_COUNT - 1)) state_in = ST_IDLE;
         ST_IDLE:       if (req_valid) state_in = ST_DIV_GO;
         ST_DIV_GO:     state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_rsp.done) state_in = (sel_ff == 2'd3) ? ST_CHECK : ST_DIV_GO;
         end
         ST_CHECK: begin
            if (outside) state_in = ST_EMIT;
            else if (op_ff != OP_FIND_PATH) state_in = ST_CELL_RD;
            else state_in = ST_INIT_RD;
         end
         ST_CELL_RD:    state_in = ST_CELL_WR;
         ST_CELL_WR:    state_in = ST_EMIT;
         ST_INIT_RD:    state_in = ST_INIT_WR;
         ST_INIT_WR: begin
            state_in = (idx_ff == CELL_BITS'(CELL_COUNT - 1)) ? ST_PUSH_SRC : ST_INIT_RD;
         end
         ST_PUSH_SRC:   state_in = ST_SCAN_START;
         ST_SCAN_START: state_in = (cnt_ff == '0) ? ST_FIN_RD : ST_SCAN;
         ST_SCAN:       if (!issue && !pend_ff) state_in = ST_RM_RD;
         ST_RM_RD:      state_in = ST_RM_WR;
         ST_RM_WR:      state_in = (best_ff.node == tgt_cell) ? ST_FIN_RD : ST_POP_CHK;
         ST_POP_CHK:    state_in = info_rd.closed ? ST_SCAN_START : ST_NB;
         ST_NB: begin
            if (nb.ok) state_in = ST_NB_CHK;
            else if (last_dir) state_in = ST_SCAN_START;
         end
         ST_NB_CHK:     state_in = last_dir ? ST_SCAN_START : ST_NB;
         ST_FIN_RD:     state_in = ST_FIN_CHK;
         ST_FIN_CHK:    state_in = search_fail ? ST_EMIT : ST_BT;
         ST_BT: begin
            if (cur_ff == src_cell || steps_ff == CELL_BITS'(CELL_COUNT - 1))
               state_in = ST_OUT_RD;
            else
               state_in = ST_BT_CHK;
         end
         ST_BT_CHK:     state_in = ST_BT;
         ST_OUT_RD:     state_in = (n_ff == '0) ? ST_EMIT : ST_OUT_WAIT;
         ST_OUT_WAIT:   state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_ready) state_in = rsp_last_ff ? ST_IDLE : ST_OUT_RD;
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      idx_in       = idx_ff;
      tile_size_in = csr_valid ? csr_tile_size : tile_size_ff;
      op_in        = op_ff;
      world_in     = world_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      goal_x_in    = goal_x_ff;
      goal_y_in    = goal_y_ff;
      sel_in       = sel_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      pos_out_in   = pos_out_ff;
      goal_out_in  = goal_out_ff;
      cnt_in       = cnt_ff;
      rd_idx_in    = rd_idx_ff;
      seq_in       = seq_ff;
      pend_in      = pend_ff;
      have_best_in = have_best_ff;
      cmp_idx_in   = cmp_idx_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      best_f_in    = best_f_ff;
      dir_in       = dir_ff;
      nb_in        = nb_ff;
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      reached_in   = reached_ff;
      n_in         = n_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_occ_in   = rsp_occ_ff;
      rsp_px_in    = rsp_px_ff;
      rsp_py_in    = rsp_py_ff;
      rsp_last_in  = rsp_last_ff;

      wall_we  = 1'b0;
      wall_wa  = idx_ff;
      wall_wd  = 1'b0;
      wall_ra  = src_cell;
      info_we  = 1'b0;
      info_wa  = best_ff.node;
      info_wd  = info_rd;
      info_ra  = best_ff.node;
      open_we  = 1'b0;
      open_wa  = best_idx_ff;
      open_wd  = open_rd;
      open_ra  = rd_idx_ff[OPEN_BITS-1:0];
      stack_we = 1'b0;
      stack_wa = n_ff[CELL_BITS-1:0];
      stack_wd = cur_ff;
      stack_ra = n_ff[CELL_BITS-1:0];

      div_req.start    = 1'b0;
      div_req.dividend = pos_x_ff;
      div_req.divisor  = world_ff ? eff_size : TILE_W'(1);
      unique case (sel_ff)
         2'd0: div_req.dividend = pos_x_ff;
         2'd1: div_req.dividend = pos_y_ff;
         2'd2: div_req.dividend = goal_x_ff;
         default: div_req.dividend = goal_y_ff;
      endcase
      if (sel_ff[1]) div_req.divisor = eff_size;

      unique case (state_ff)
         ST_CLEAR: begin
            wall_we = 1'b1;
            idx_in  = idx_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_opcode;
               world_in  = req_from_world;
               pos_x_in  = req_pos_x;
               pos_y_in  = req_pos_y;
               goal_x_in = req_goal_x;
               goal_y_in = req_goal_y;
               sel_in    = '0;
            end
         end
         ST_DIV_GO: div_req.start = 1'b1;
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               sel_in = sel_ff + 1'b1;
               unique case (sel_ff)
                  2'd0: begin
                     px_in      = div_rsp.quotient[GRID_BITS-1:0];
                     pos_out_in = |div_rsp.quotient[COORD_W-1:GRID_BITS];
                  end
                  2'd1: begin
                     py_in      = div_rsp.quotient[GRID_BITS-1:0];
                     pos_out_in = pos_out_ff | (|div_rsp.quotient[COORD_W-1:GRID_BITS]);
                  end
                  2'd2: begin
                     tx_in       = div_rsp.quotient[GRID_BITS-1:0];
                     goal_out_in = |div_rsp.quotient[COORD_W-1:GRID_BITS];
                  end
                  default: begin
                     ty_in       = div_rsp.quotient[GRID_BITS-1:0];
                     goal_out_in = goal_out_ff | (|div_rsp.quotient[COORD_W-1:GRID_BITS]);
                  end
               endcase
            end
         end
         ST_CHECK: begin
            idx_in = '0;
            if (outside) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_OUTSIDE;
               rsp_occ_in   = 1'b0;
               rsp_px_in    = '0;
               rsp_py_in    = '0;
               rsp_last_in  = 1'b1;
            end
         end
         ST_CELL_RD: wall_ra = src_cell;
         ST_CELL_WR: begin
            wall_we      = op_ff != OP_QUERY;
            wall_wa      = src_cell;
            wall_wd      = cell_bit;
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_CELL;
            rsp_occ_in   = cell_bit;
            rsp_px_in    = '0;
            rsp_py_in    = '0;
            rsp_last_in  = 1'b1;
         end
         ST_INIT_RD: wall_ra = idx_ff;
         ST_INIT_WR: begin
            info_we = 1'b1;
            info_wa = idx_ff;
            info_wd = '{closed: wall_rd, known: 1'b0, cost: '0, from: '0};
            idx_in  = idx_ff + 1'b1;
         end
         ST_PUSH_SRC: begin
            open_we    = 1'b1;
            open_wa    = '0;
            open_wd    = '{g: '0, node: src_cell, seq: '0};
            cnt_in     = OPEN_CNT_BITS'(1);
            seq_in     = SEQ_W'(1);
            reached_in = 1'b0;
         end
         ST_SCAN_START: begin
            rd_idx_in    = '0;
            pend_in      = 1'b0;
            have_best_in = 1'b0;
         end
         ST_SCAN: begin
            open_ra = rd_idx_ff[OPEN_BITS-1:0];
            pend_in = issue;
            if (issue) begin
               rd_idx_in  = rd_idx_ff + 1'b1;
               cmp_idx_in = rd_idx_ff[OPEN_BITS-1:0];
            end
            if (pend_ff && scan_better) begin
               best_in      = open_rd;
               best_f_in    = scan_f;
               best_idx_in  = cmp_idx_ff;
               have_best_in = 1'b1;
            end
         end
         ST_RM_RD: begin
            open_ra = OPEN_BITS'(cnt_ff - 1'b1);
            cnt_in  = cnt_ff - 1'b1;
         end
         ST_RM_WR: begin
            open_we = 1'b1;
            open_wa = best_idx_ff;
            open_wd = open_rd;
            info_ra = best_ff.node;
            if (best_ff.node == tgt_cell) reached_in = 1'b1;
         end
         ST_POP_CHK: begin
            dir_in = '0;
            if (!info_rd.closed) begin
               info_we        = 1'b1;
               info_wa        = best_ff.node;
               info_wd        = info_rd;
               info_wd.closed = 1'b1;
            end
         end
         ST_NB: begin
            info_ra = nb.node;
            nb_in   = nb.node;
            if (!nb.ok) dir_in = dir_ff + 1'b1;
         end
         ST_NB_CHK: begin
            dir_in = dir_ff + 1'b1;
            if (!info_rd.closed) begin
               if (!info_rd.known || info_rd.cost > nb_cost) begin
                  info_we = 1'b1;
                  info_wa = nb_ff;
                  info_wd = '{closed: 1'b0, known: 1'b1, cost: nb_cost, from: best_ff.node};
               end
               if (!open_full) begin
                  open_we = 1'b1;
                  open_wa = cnt_ff[OPEN_BITS-1:0];
                  open_wd = '{g: best_ff.g + 1'b1, node: nb_ff, seq: seq_ff};
                  cnt_in  = cnt_ff + 1'b1;
                  seq_in  = seq_ff + 1'b1;
               end
            end
         end
         ST_FIN_RD: info_ra = tgt_cell;
         ST_FIN_CHK: begin
            cur_in   = tgt_cell;
            n_in     = '0;
            steps_in = '0;
            if (search_fail) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_EMPTY;
               rsp_occ_in   = 1'b0;
               rsp_px_in    = '0;
               rsp_py_in    = '0;
               rsp_last_in  = 1'b1;
            end
         end
         ST_BT: begin
            info_ra = cur_ff;
            if (!(cur_ff == src_cell || steps_ff == CELL_BITS'(CELL_COUNT - 1))) begin
               stack_we = 1'b1;
               stack_wa = n_ff[CELL_BITS-1:0];
               stack_wd = cur_ff;
               n_in     = n_ff + 1'b1;
            end
         end
         ST_BT_CHK: begin
            cur_in   = info_rd.from;
            steps_in = steps_ff + 1'b1;
         end
         ST_OUT_RD: begin
            stack_ra = CELL_BITS'(n_ff - 1'b1);
            if (n_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_WAYPOINT;
               rsp_occ_in   = 1'b0;
               rsp_px_in    = {goal_x_ff, 1'b0};
               rsp_py_in    = {goal_y_ff, 1'b0};
               rsp_last_in  = 1'b1;
            end else begin
               n_in = n_ff - 1'b1;
            end
         end
         ST_OUT_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_WAYPOINT;
            rsp_occ_in   = 1'b0;
            rsp_px_in    = POINT_W'(wp_x) * POINT_W'(eff_size);
            rsp_py_in    = POINT_W'(wp_y) * POINT_W'(eff_size);
            rsp_last_in  = 1'b0;
         end
         ST_EMIT: if (rsp_ready) rsp_valid_in = 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         tile_size_ff <= TILE_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         tile_size_ff <= tile_size_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      world_ff     <= world_in;
      pos_x_ff     <= pos_x_in;
      pos_y_ff     <= pos_y_in;
      goal_x_ff    <= goal_x_in;
      goal_y_ff    <= goal_y_in;
      sel_ff       <= sel_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      tx_ff        <= tx_in;
      ty_ff        <= ty_in;
      pos_out_ff   <= pos_out_in;
      goal_out_ff  <= goal_out_in;
      rd_idx_ff    <= rd_idx_in;
      seq_ff       <= seq_in;
      have_best_ff <= have_best_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_idx_ff  <= best_idx_in;
      best_ff      <= best_in;
      best_f_ff    <= best_f_in;
      dir_ff       <= dir_in;
      nb_ff        <= nb_in;
      cur_ff       <= cur_in;
      steps_ff     <= steps_in;
      reached_ff   <= reached_in;
      n_ff         <= n_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_occ_ff   <= rsp_occ_in;
      rsp_px_ff    <= rsp_px_in;
      rsp_py_ff    <= rsp_py_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ready    = state_ff == ST_IDLE;
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_occupied = rsp_occ_ff;
   assign rsp_point_x2 = rsp_px_ff;
   assign rsp_point_y2 = rsp_py_ff;
   assign rsp_last     = rsp_last_ff;

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= OPEN_CNT_BITS'(OPEN_DEPTH))
      else $error("open list count above its depth");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_WAYPOINT |-> rsp_last)
      else $error("non-waypoint result without last");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid && !req_ready)
      else $error("result or new transaction right after accept");
endmodule

/* src/gap_ram.sv */
// generic single write port ram with one registered read port
// no dependencies
module gap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* src/gap_div.sv */
// iterative restoring divider, one quotient bit per cycle
// depends on gap_pkg
module gap_div (
   input  logic                clock,
   input  logic                reset,
   input  gap_pkg::div_req_type div_req,
   output gap_pkg::div_rsp_type div_rsp
);
   import gap_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TILE_W-1:0]    rem_ff, rem_in;
   logic [COORD_W-1:0]   quo_ff, quo_in;
   logic [TILE_W-1:0]    dvs_ff, dvs_in;
   logic [TILE_W:0]      rem_sh;
   logic                 fits;

   assign rem_sh = {rem_ff, quo_ff[COORD_W-1]};
   assign fits   = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? TILE_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[TILE_W-1:0];
         quo_in = {quo_ff[COORD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule
